// ----- rtl/bbc_pkg.sv -----
// Bracket balance checker package: item types, command queue types,
// stack sizing constants and bracket character codes. No dependencies.
`default_nettype none

package bbc_pkg;

  localparam int unsigned STACK_DEPTH  = 32;
  localparam int unsigned LINE_BITS    = 16;
  localparam int unsigned LINE_FIELD_W = 16;
  localparam int unsigned LINE_W       = (LINE_BITS < LINE_FIELD_W) ? LINE_BITS : LINE_FIELD_W;
  localparam int unsigned CNT_W        = $clog2(STACK_DEPTH + 1);
  localparam int unsigned ADDR_W       = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int unsigned QUEUE_DEPTH  = 2;

  localparam logic [7:0] OPEN_PAREN  = 8'h28;
  localparam logic [7:0] CLOSE_PAREN = 8'h29;
  localparam logic [7:0] OPEN_BRACE  = 8'h7B;
  localparam logic [7:0] CLOSE_BRACE = 8'h7D;

  typedef enum logic [2:0] {
    KIND_UNMATCHED = 3'd0,
    KIND_MISMATCH  = 3'd1,
    KIND_MISSING   = 3'd2,
    KIND_OVERFLOW  = 3'd3,
    KIND_DONE      = 3'd4
  } kind_e;

  typedef enum logic [1:0] {
    CMD_OPEN,
    CMD_CLOSE,
    CMD_END
  } cmd_e;

  typedef struct packed {
    logic                    op;
    logic [7:0]              char_code;
    logic [LINE_FIELD_W-1:0] line_number;
  } in_item_t;

  typedef struct packed {
    kind_e                   error_kind;
    logic [7:0]              found_char;
    logic [LINE_FIELD_W-1:0] found_line;
    logic [7:0]              open_char;
    logic [LINE_FIELD_W-1:0] open_line;
    logic                    last;
  } out_item_t;

  typedef struct packed {
    cmd_e              kind;
    logic              is_brace;
    logic [7:0]        char_code;
    logic [LINE_W-1:0] line;
  } cmd_t;

  typedef struct packed {
    logic empty;
    logic full;
  } q_status_t;

  typedef struct packed {
    logic              is_brace;
    logic [LINE_W-1:0] line;
  } entry_t;

endpackage

`default_nettype wire

// ----- rtl/bbc_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// Standalone; no package use.
`default_nettype none

module bbc_ram #(
  parameter int unsigned WIDTH  = 8,
  parameter int unsigned DEPTH  = 16,
  parameter int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk_i,
  input  wire logic              we_i,
  input  wire logic [ADDR_W-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]  wdata_i,
  input  wire logic              re_i,
  input  wire logic [ADDR_W-1:0] raddr_i,
  output      logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ----- rtl/bbc_front.sv -----
// Front end: accepts input items and turns brackets and end-of-text into
// stack commands. Depends on bbc_pkg.
`default_nettype none

module bbc_front (
  input  wire logic                 in_valid_i,
  input  wire bbc_pkg::in_item_t    in_i,
  output      logic                 in_stall_o,
  input  wire bbc_pkg::q_status_t   q_status_i,
  output      logic                 q_push_o,
  output      bbc_pkg::cmd_t        q_cmd_o
);

  logic is_open;
  logic is_close;

  assign in_stall_o = q_status_i.full;

  always_comb begin
    is_open  = (in_i.char_code == bbc_pkg::OPEN_PAREN) ||
               (in_i.char_code == bbc_pkg::OPEN_BRACE);
    is_close = (in_i.char_code == bbc_pkg::CLOSE_PAREN) ||
               (in_i.char_code == bbc_pkg::CLOSE_BRACE);

    q_cmd_o.char_code = in_i.char_code;
    q_cmd_o.line      = in_i.line_number[bbc_pkg::LINE_W-1:0];
    q_cmd_o.is_brace  = (in_i.char_code == bbc_pkg::OPEN_BRACE) ||
                        (in_i.char_code == bbc_pkg::CLOSE_BRACE);

    priority if (in_i.op) begin
      q_cmd_o.kind = bbc_pkg::CMD_END;
    end else if (is_open) begin
      q_cmd_o.kind = bbc_pkg::CMD_OPEN;
    end else begin
      q_cmd_o.kind = bbc_pkg::CMD_CLOSE;
    end

    // other characters are dropped here
    q_push_o = in_valid_i && !q_status_i.full && (in_i.op || is_open || is_close);
  end

endmodule

`default_nettype wire

// ----- rtl/bbc_queue.sv -----
// Short command queue between front end and stack engine.
// Depends on bbc_pkg.
`default_nettype none

module bbc_queue (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               push_i,
  input  wire bbc_pkg::cmd_t      push_cmd_i,
  input  wire logic               pop_i,
  output      bbc_pkg::cmd_t      head_o,
  output      bbc_pkg::q_status_t status_o
);

  localparam int unsigned PTR_W = (bbc_pkg::QUEUE_DEPTH > 1) ?
                                  $clog2(bbc_pkg::QUEUE_DEPTH) : 1;
  localparam int unsigned FILL_W = $clog2(bbc_pkg::QUEUE_DEPTH + 1);

  bbc_pkg::cmd_t     slot_q [bbc_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0]  rd_ptr_q, rd_ptr_d;
  logic [FILL_W-1:0] fill_q, fill_d;
  logic              do_push;
  logic              do_pop;

  always_comb begin
    status_o.empty = (fill_q == '0);
    status_o.full  = (fill_q == FILL_W'(bbc_pkg::QUEUE_DEPTH));
    head_o         = slot_q[rd_ptr_q];
    do_push        = push_i && !status_o.full;
    do_pop         = pop_i && !status_o.empty;

    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(bbc_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(bbc_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    fill_d = fill_q + FILL_W'(do_push) - FILL_W'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= push_cmd_i;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/bbc_back.sv -----
// Stack engine: executes queued commands against the bracket stack RAM
// and drives the result register. Depends on bbc_pkg and bbc_ram.
`default_nettype none

module bbc_back (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire bbc_pkg::cmd_t      q_head_i,
  input  wire bbc_pkg::q_status_t q_status_i,
  output      logic               q_pop_o,
  output      logic               out_valid_o,
  output      bbc_pkg::out_item_t out_o,
  input  wire logic               out_stall_i
);

  localparam int unsigned CNT_W  = bbc_pkg::CNT_W;
  localparam int unsigned ADDR_W = bbc_pkg::ADDR_W;
  localparam int unsigned LFW    = bbc_pkg::LINE_FIELD_W;

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_DONE
  } state_e;

  state_e             state_q, state_d;
  logic [CNT_W-1:0]   count_q, count_d;
  bbc_pkg::cmd_t      cur_q, cur_d;
  logic               out_valid_d;
  bbc_pkg::out_item_t out_d;

  logic [CNT_W-1:0]   cnt_m1;
  logic [CNT_W-1:0]   cnt_m2;
  logic               full;
  logic               can_emit;
  logic               emit;
  bbc_pkg::out_item_t item;
  logic               we;
  logic               re;
  logic [ADDR_W-1:0]  raddr;
  bbc_pkg::entry_t    wentry;
  bbc_pkg::entry_t    rentry;

  bbc_ram #(
    .WIDTH ($bits(bbc_pkg::entry_t)),
    .DEPTH (bbc_pkg::STACK_DEPTH),
    .ADDR_W(ADDR_W)
  ) u_stack (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(count_q[ADDR_W-1:0]),
    .wdata_i(wentry),
    .re_i   (re),
    .raddr_i(raddr),
    .rdata_o(rentry)
  );

  always_comb begin
    cnt_m1   = count_q - CNT_W'(1);
    cnt_m2   = count_q - CNT_W'(2);
    full     = (count_q == CNT_W'(bbc_pkg::STACK_DEPTH));
    can_emit = !out_valid_o || !out_stall_i;
    raddr    = (state_q == S_IDLE) ? cnt_m1[ADDR_W-1:0] : cnt_m2[ADDR_W-1:0];

    wentry.is_brace = q_head_i.is_brace;
    wentry.line     = q_head_i.line;

    state_d = state_q;
    count_d = count_q;
    cur_d   = cur_q;
    q_pop_o = 1'b0;
    we      = 1'b0;
    re      = 1'b0;
    emit    = 1'b0;
    item    = '0;

    unique case (state_q)
      S_IDLE: begin
        if (!q_status_i.empty) begin
          unique case (q_head_i.kind)
            bbc_pkg::CMD_OPEN: begin
              item.error_kind = bbc_pkg::KIND_OVERFLOW;
              item.found_char = q_head_i.char_code;
              item.found_line = LFW'(q_head_i.line);
              if (!full) begin
                we      = 1'b1;
                count_d = count_q + CNT_W'(1);
                q_pop_o = 1'b1;
              end else if (can_emit) begin
                emit    = 1'b1;
                q_pop_o = 1'b1;
              end
            end
            bbc_pkg::CMD_CLOSE: begin
              item.error_kind = bbc_pkg::KIND_UNMATCHED;
              item.found_char = q_head_i.char_code;
              item.found_line = LFW'(q_head_i.line);
              if (count_q != '0) begin
                re      = 1'b1;
                cur_d   = q_head_i;
                q_pop_o = 1'b1;
                state_d = S_READ;
              end else if (can_emit) begin
                emit    = 1'b1;
                q_pop_o = 1'b1;
              end
            end
            default: begin
              item.error_kind = bbc_pkg::KIND_DONE;
              item.found_line = LFW'(q_head_i.line);
              item.last       = 1'b1;
              if (count_q != '0) begin
                re      = 1'b1;
                cur_d   = q_head_i;
                q_pop_o = 1'b1;
                state_d = S_READ;
              end else if (can_emit) begin
                emit    = 1'b1;
                q_pop_o = 1'b1;
              end
            end
          endcase
        end
      end
      S_READ: begin
        item.found_line = LFW'(cur_q.line);
        item.open_char  = rentry.is_brace ? bbc_pkg::OPEN_BRACE : bbc_pkg::OPEN_PAREN;
        item.open_line  = LFW'(rentry.line);
        if (cur_q.kind == bbc_pkg::CMD_CLOSE) begin
          item.error_kind = bbc_pkg::KIND_MISMATCH;
          item.found_char = cur_q.char_code;
          if (rentry.is_brace == cur_q.is_brace) begin
            count_d = cnt_m1;
            state_d = S_IDLE;
          end else if (can_emit) begin
            emit    = 1'b1;
            count_d = cnt_m1;
            state_d = S_IDLE;
          end
        end else begin
          item.error_kind = bbc_pkg::KIND_MISSING;
          item.found_char = rentry.is_brace ? bbc_pkg::CLOSE_BRACE : bbc_pkg::CLOSE_PAREN;
          if (can_emit) begin
            emit    = 1'b1;
            count_d = cnt_m1;
            if (count_q == CNT_W'(1)) begin
              state_d = S_DONE;
            end else begin
              re = 1'b1;
            end
          end
        end
      end
      S_DONE: begin
        item.error_kind = bbc_pkg::KIND_DONE;
        item.found_line = LFW'(cur_q.line);
        item.last       = 1'b1;
        if (can_emit) begin
          emit    = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    out_d       = out_o;
    out_valid_d = out_valid_o;
    if (emit) begin
      out_valid_d = 1'b1;
      out_d       = item;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      cur_q       <= '0;
      out_valid_o <= 1'b0;
      out_o       <= '0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      cur_q       <= cur_d;
      out_valid_o <= out_valid_d;
      out_o       <= out_d;
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(bbc_pkg::STACK_DEPTH))
    else $error("stack count beyond depth");

  a_no_write_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    we |-> !full)
    else $error("stack write while full");

  a_read_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_READ) |-> (count_q != '0))
    else $error("stack read state with empty stack");

  a_done_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE) |-> (count_q == '0))
    else $error("done marker before stack drained");

  a_last_is_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_o.last) |-> (out_o.error_kind == bbc_pkg::KIND_DONE))
    else $error("last set on a non-done item");

endmodule

`default_nettype wire

// ----- rtl/bracket_balance_checker.sv -----
// Bracket balance checker top level: front end, command queue, stack engine.
// Depends on bbc_pkg, bbc_front, bbc_queue, bbc_back (and bbc_ram).
//
//   channel | direction | payload             | handshake
//   in      | input     | bbc_pkg::in_item_t  | in_valid_i / in_stall_o
//   out     | output    | bbc_pkg::out_item_t | out_valid_o / out_stall_i
//
// Opening brackets and unmatched closings are handled in the idle state;
// a closing on a nonempty stack passes the read state, as the stack RAM read
// is registered. End of text emits a missing item per stacked entry, then
// the done item. Non-bracket characters are dropped at the front.
// Reset clears the stack count and queue; the stack RAM is never cleared.
// A stalled output holds the engine; the two-entry queue still fills up.
`default_nettype none

module bracket_balance_checker (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  input  wire bbc_pkg::in_item_t  in_i,
  output      logic               in_stall_o,
  output      logic               out_valid_o,
  output      bbc_pkg::out_item_t out_o,
  input  wire logic               out_stall_i
);

  bbc_pkg::q_status_t q_status;
  logic               q_push;
  bbc_pkg::cmd_t      q_cmd;
  logic               q_pop;
  bbc_pkg::cmd_t      q_head;

  bbc_front u_front (
    .in_valid_i(in_valid_i),
    .in_i      (in_i),
    .in_stall_o(in_stall_o),
    .q_status_i(q_status),
    .q_push_o  (q_push),
    .q_cmd_o   (q_cmd)
  );

  bbc_queue u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (q_push),
    .push_cmd_i(q_cmd),
    .pop_i     (q_pop),
    .head_o    (q_head),
    .status_o  (q_status)
  );

  bbc_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_head_i   (q_head),
    .q_status_i (q_status),
    .q_pop_o    (q_pop),
    .out_valid_o(out_valid_o),
    .out_o      (out_o),
    .out_stall_i(out_stall_i)
  );

endmodule

`default_nettype wire
